### src/tcw_pkg.sv
// Shared constants and types for the text console writer.
package tcw_pkg;

  // Field widths of the request and response transfers
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned ATTR_W    = 8;
  localparam int unsigned CELL_W    = ATTR_W + CHAR_W;
  localparam int unsigned IDX_W     = 11;
  localparam int unsigned ROW_OUT_W = 5;
  localparam int unsigned COL_OUT_W = 7;

  // Default screen geometry
  localparam int unsigned ROWS_DEF = 25;
  localparam int unsigned COLS_DEF = 80;

  // Character and attribute codes
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

  // Request opcodes
  typedef enum logic {
    OP_PUT  = 1'b0,
    OP_READ = 1'b1
  } tcw_op_e;

endpackage

### src/tcw_req_if.sv
// Request channel: opcode, character and cell index with valid/ready.
interface tcw_req_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  tcw_op_e           opcode;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, output opcode, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input opcode, input char_code, input cell_index,
                  output ready);
endinterface

### src/tcw_rsp_if.sv
// Response channel: cell value and cursor position with valid/ready.
interface tcw_rsp_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CELL_W-1:0]    cell_value;
  logic [ROW_OUT_W-1:0] cursor_row;
  logic [COL_OUT_W-1:0] cursor_col;

  modport source (output valid, output cell_value, output cursor_row, output cursor_col,
                  input ready);
  modport sink   (input valid, input cell_value, input cursor_row, input cursor_col,
                  output ready);
endinterface

### src/text_console_writer.sv
// Text console writer: cursor sequencer over a shared screen cell memory.
//
//   channel | direction | handshake     | payload
//   --------+-----------+---------------+-----------------------------------
//   req_i   | in        | valid / ready | opcode, char_code, cell_index
//   rsp_o   | out       | valid / ready | cell_value, cursor_row, cursor_col
//   cfg     | in        | cfg_we_i      | cfg_data_i (attribute byte)
//
// A put passes through ST_DONE and a read through ST_READ and ST_DONE before
// the response register loads. A put that moves past the bottom row runs a
// scroll through the cell memory: a copy sweep (ST_COPY), a drain step
// (ST_DRAIN) and a blank sweep of the bottom row (ST_BLANK). After reset a
// clearing pass fills the screen with grey spaces; req_i is not ready meanwhile.
// A stalled response holds the sequencer in its final state until taken.
module text_console_writer import tcw_pkg::*; #(
  parameter int unsigned ROWS = ROWS_DEF,
  parameter int unsigned COLS = COLS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_data_i,
  tcw_req_if.sink           req_i,
  tcw_rsp_if.source         rsp_o
);

  localparam int unsigned CELLS = ROWS * COLS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLS);

  localparam logic [AW-1:0] LAST_ADDR   = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_STRIDE  = AW'(COLS);
  localparam logic [AW-1:0] BOTTOM_BASE = AW'((ROWS - 1) * COLS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic [AW-1:0]        sweep_q;
  logic [AW-1:0]        copy_dst_q;
  logic                 copy_pend_q;
  logic [RW-1:0]        row_q;
  logic [CW-1:0]        col_q;
  logic [AW-1:0]        base_q;
  logic                 in_range_q;
  logic [CELL_W-1:0]    value_q;
  logic                 rsp_valid_q;
  logic [CELL_W-1:0]    rsp_cell_q;
  logic [ROW_OUT_W-1:0] rsp_row_q;
  logic [COL_OUT_W-1:0] rsp_col_q;
  logic [ATTR_W-1:0]    attr_q;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [CELL_W-1:0]    mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [CELL_W-1:0]    mem_rdata;

  logic                 req_xfer;
  logic                 is_newline;
  logic [CW:0]          col_inc;
  logic                 line_end;
  logic                 on_last_row;
  logic                 rsp_load;

  tcw_cell_mem #(
    .Depth (CELLS),
    .AddrW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_xfer    = req_i.valid && (state_q == ST_IDLE);

  // Cursor advance terms
  assign is_newline  = (req_i.char_code == NEWLINE_CODE);
  assign col_inc     = {1'b0, col_q} + (CW+1)'(1);
  assign line_end    = is_newline || (32'(col_inc) == COLS);
  assign on_last_row = (32'(row_q) == ROWS - 1);

  // Response register loads once the slot is free
  assign rsp_load    = (state_q == ST_DONE) && (!rsp_valid_q || rsp_o.ready);

  // Attribute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_data_i;
    end
  end

  // Memory port steering per sequencer state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_q;
    mem_wdata = {attr_q, SPACE_CODE};
    mem_re    = 1'b0;
    mem_raddr = sweep_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = {ATTR_RESET, SPACE_CODE};
      end
      ST_IDLE: begin
        if (req_xfer) begin
          if (req_i.opcode == OP_READ) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(req_i.cell_index);
          end else if (!is_newline) begin
            mem_we    = 1'b1;
            mem_waddr = base_q + AW'(col_q);
            mem_wdata = {attr_q, req_i.char_code};
          end
        end
      end
      ST_COPY: begin
        // read one line ahead, write the cell read last cycle
        mem_re    = 1'b1;
        mem_we    = copy_pend_q;
        mem_waddr = copy_dst_q;
        mem_wdata = mem_rdata;
      end
      ST_DRAIN: begin
        mem_we    = 1'b1;
        mem_waddr = copy_dst_q;
        mem_wdata = mem_rdata;
      end
      ST_BLANK: begin
        mem_we = 1'b1;
      end
      ST_READ, ST_DONE: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer, cursor and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      copy_dst_q  <= '0;
      copy_pend_q <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      base_q      <= '0;
      in_range_q  <= 1'b0;
      value_q     <= '0;
      rsp_valid_q <= 1'b0;
      rsp_cell_q  <= '0;
      rsp_row_q   <= '0;
      rsp_col_q   <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (sweep_q == LAST_ADDR) begin
            sweep_q <= '0;
            state_q <= ST_IDLE;
          end else begin
            sweep_q <= sweep_q + AW'(1);
          end
        end
        ST_IDLE: begin
          if (req_i.valid) begin
            value_q <= '0;
            if (req_i.opcode == OP_READ) begin
              in_range_q <= (32'(req_i.cell_index) < CELLS);
              state_q    <= ST_READ;
            end else if (line_end) begin
              col_q <= '0;
              if (on_last_row) begin
                sweep_q     <= ROW_STRIDE;
                copy_pend_q <= 1'b0;
                state_q     <= ST_COPY;
              end else begin
                row_q   <= row_q + RW'(1);
                base_q  <= base_q + ROW_STRIDE;
                state_q <= ST_DONE;
              end
            end else begin
              col_q   <= CW'(col_inc);
              state_q <= ST_DONE;
            end
          end
        end
        ST_READ: begin
          value_q <= in_range_q ? mem_rdata : '0;
          state_q <= ST_DONE;
        end
        ST_COPY: begin
          copy_pend_q <= 1'b1;
          copy_dst_q  <= sweep_q - ROW_STRIDE;
          if (sweep_q == LAST_ADDR) begin
            state_q <= ST_DRAIN;
          end else begin
            sweep_q <= sweep_q + AW'(1);
          end
        end
        ST_DRAIN: begin
          copy_pend_q <= 1'b0;
          sweep_q     <= BOTTOM_BASE;
          state_q     <= ST_BLANK;
        end
        ST_BLANK: begin
          if (sweep_q == LAST_ADDR) begin
            state_q <= ST_DONE;
          end else begin
            sweep_q <= sweep_q + AW'(1);
          end
        end
        ST_DONE: begin
          if (rsp_load) begin
            rsp_cell_q  <= value_q;
            rsp_row_q   <= ROW_OUT_W'(row_q);
            rsp_col_q   <= COL_OUT_W'(col_q);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.cell_value = rsp_cell_q;
  assign rsp_o.cursor_row = rsp_row_q;
  assign rsp_o.cursor_col = rsp_col_q;

  // Cursor stays on screen and the line base tracks the row
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < COLS) else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_q) < ROWS) else $error("cursor row out of range");

  a_base_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(base_q) == 32'(row_q) * COLS) else $error("line base does not match row");

  // Every memory write lands inside the screen
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(mem_waddr) < CELLS)) else $error("memory write out of range");

  // A request transfer always takes the sequencer out of idle
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |=> (state_q != ST_IDLE)) else $error("sequencer idle after transfer");

endmodule

### src/tcw_cell_mem.sv
// Screen cell memory: one write port, one read port with registered data.
module tcw_cell_mem import tcw_pkg::*; #(
  parameter int unsigned Depth = ROWS_DEF * COLS_DEF,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [CELL_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [CELL_W-1:0] rdata_o
);

  logic [CELL_W-1:0] mem_q [Depth];
  logic [CELL_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data available the cycle after the request
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
